// ===== rtl/core/fdc_hp_pkg.sv =====
// Package for the floppy head-positioning register block.
// Holds the request and register-file types, bus codes, opcode groups and status bits.
// No dependencies; used by fdc_hp_cmd and the top level.
package fdc_hp_pkg;

   localparam int DEF_NUM_DRIVES = 2;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   // Bus access kinds carried in the cmd field.
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Register selects.
   localparam logic [1:0] SEL_STATUS = 2'd0;
   localparam logic [1:0] SEL_TRACK  = 2'd1;
   localparam logic [1:0] SEL_SECTOR = 2'd2;
   localparam logic [1:0] SEL_DATA   = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_DRIVE_SELECT = 1'b0;
   localparam logic CSR_DISK_PRESENT = 1'b1;

   // Upper nibble of a command byte.
   localparam logic [3:0] OP_RESTORE     = 4'h0;
   localparam logic [3:0] OP_SEEK        = 4'h1;
   localparam logic [3:0] OP_STEP        = 4'h2;
   localparam logic [3:0] OP_STEP_U      = 4'h3;
   localparam logic [3:0] OP_STEP_IN     = 4'h4;
   localparam logic [3:0] OP_STEP_IN_U   = 4'h5;
   localparam logic [3:0] OP_STEP_OUT    = 4'h6;
   localparam logic [3:0] OP_STEP_OUT_U  = 4'h7;
   localparam logic [3:0] OP_FORCE_INT   = 4'hD;
   localparam int         UPDATE_BIT     = 4;

   localparam logic [7:0] LAST_TRACK  = 8'd79;
   localparam logic [6:0] MOTOR_TICKS = 7'd100;

   localparam logic [7:0] ST_MOTOR   = 8'h80;
   localparam logic [7:0] ST_HEAD    = 8'h20;
   localparam logic [7:0] ST_SEEKERR = 8'h10;
   localparam logic [7:0] ST_TRACK0  = 8'h04;
   localparam int         ST_BUSY_BIT = 0;

   typedef struct packed {
      logic [7:0] write_data;
      logic [1:0] reg_sel;
      logic [1:0] cmd;
   } req_type;

   typedef struct packed {
      logic [7:0] track;
      logic [7:0] sector;
      logic [7:0] data;
      logic [7:0] status;
      logic       step_outward;
      logic       motor_on;
      logic [6:0] countdown;
   } regs_type;

   // Head track update for the selected drive.
   typedef struct packed {
      logic       we;
      logic [7:0] track;
   } head_upd_type;

endpackage

// ===== rtl/core/fdc_hp_cmd.sv =====
// Next-state logic of the floppy head-positioning registers for one request.
// Decodes bus reads, register writes, Type I commands, force interrupt and motor ticks.
// Depends on fdc_hp_pkg.
module fdc_hp_cmd (
   input  fdc_hp_pkg::req_type      req_i,
   input  fdc_hp_pkg::regs_type     regs_i,
   input  logic [7:0]               head_i,
   input  logic                     disk_i,
   output fdc_hp_pkg::regs_type     regs_o,
   output fdc_hp_pkg::head_upd_type head_o,
   output logic [7:0]               read_data_o
);

   logic [7:0] step_in_trk;
   logic [7:0] step_out_trk;
   logic [7:0] step_trk;
   logic       step_dir_out;
   logic       is_step;

   // A head left above the last track by a seek clamps back to it on any step.
   assign step_in_trk  = (head_i >= fdc_hp_pkg::LAST_TRACK) ? fdc_hp_pkg::LAST_TRACK
                                                            : head_i + 8'd1;
   assign step_out_trk = (head_i == 8'd0) ? 8'd0 :
                         (head_i > fdc_hp_pkg::LAST_TRACK + 8'd1) ? fdc_hp_pkg::LAST_TRACK
                                                                  : head_i - 8'd1;

   always_comb begin
      logic [7:0] op;
      logic [7:0] target;
      op           = req_i.write_data;
      target       = regs_i.data;
      regs_o       = regs_i;
      head_o.we    = 1'b0;
      head_o.track = head_i;
      read_data_o  = 8'd0;
      is_step      = 1'b0;
      step_dir_out = regs_i.step_outward;
      step_trk     = step_in_trk;

      case (req_i.cmd)
         fdc_hp_pkg::CMD_READ: begin
            case (req_i.reg_sel)
               fdc_hp_pkg::SEL_STATUS: read_data_o = regs_i.status;
               fdc_hp_pkg::SEL_TRACK:  read_data_o = regs_i.track;
               fdc_hp_pkg::SEL_SECTOR: read_data_o = regs_i.sector;
               default:                read_data_o = regs_i.data;
            endcase
         end
         fdc_hp_pkg::CMD_WRITE: begin
            case (req_i.reg_sel)
               fdc_hp_pkg::SEL_STATUS: begin
                  case (op[7:4])
                     fdc_hp_pkg::OP_FORCE_INT: begin
                        regs_o.status = fdc_hp_pkg::ST_MOTOR | fdc_hp_pkg::ST_HEAD;
                        if (head_i == 8'd0) begin
                           regs_o.status = regs_o.status | fdc_hp_pkg::ST_TRACK0;
                        end
                        if (!disk_i) begin
                           regs_o.status = regs_o.status & ~fdc_hp_pkg::ST_MOTOR;
                        end
                        regs_o.motor_on  = 1'b1;
                        regs_o.countdown = fdc_hp_pkg::MOTOR_TICKS;
                     end
                     fdc_hp_pkg::OP_RESTORE: begin
                        regs_o.motor_on     = 1'b1;
                        regs_o.countdown    = fdc_hp_pkg::MOTOR_TICKS;
                        head_o.we           = 1'b1;
                        head_o.track        = 8'd0;
                        regs_o.track        = 8'd0;
                        regs_o.step_outward = 1'b1;
                        regs_o.status = fdc_hp_pkg::ST_MOTOR | fdc_hp_pkg::ST_HEAD |
                                        fdc_hp_pkg::ST_TRACK0 |
                                        (disk_i ? 8'd0 : fdc_hp_pkg::ST_SEEKERR);
                     end
                     fdc_hp_pkg::OP_SEEK: begin
                        regs_o.motor_on  = 1'b1;
                        regs_o.countdown = fdc_hp_pkg::MOTOR_TICKS;
                        if (target > regs_i.track) begin
                           regs_o.step_outward = 1'b0;
                        end else if (target < regs_i.track) begin
                           regs_o.step_outward = 1'b1;
                        end
                        head_o.we    = 1'b1;
                        head_o.track = target;
                        regs_o.track = target;
                        regs_o.status = fdc_hp_pkg::ST_MOTOR | fdc_hp_pkg::ST_HEAD |
                                        ((target == 8'd0) ? fdc_hp_pkg::ST_TRACK0 : 8'd0) |
                                        (disk_i ? 8'd0 : fdc_hp_pkg::ST_SEEKERR);
                     end
                     fdc_hp_pkg::OP_STEP, fdc_hp_pkg::OP_STEP_U: begin
                        is_step = 1'b1;
                     end
                     fdc_hp_pkg::OP_STEP_IN, fdc_hp_pkg::OP_STEP_IN_U: begin
                        is_step      = 1'b1;
                        step_dir_out = 1'b0;
                     end
                     fdc_hp_pkg::OP_STEP_OUT, fdc_hp_pkg::OP_STEP_OUT_U: begin
                        is_step      = 1'b1;
                        step_dir_out = 1'b1;
                     end
                     default: begin
                        // Transfer commands are not handled and leave every register alone.
                     end
                  endcase
                  if (is_step) begin
                     step_trk            = step_dir_out ? step_out_trk : step_in_trk;
                     regs_o.motor_on     = 1'b1;
                     regs_o.countdown    = fdc_hp_pkg::MOTOR_TICKS;
                     regs_o.step_outward = step_dir_out;
                     head_o.we           = 1'b1;
                     head_o.track        = step_trk;
                     if (op[fdc_hp_pkg::UPDATE_BIT]) begin
                        regs_o.track = step_trk;
                     end
                     regs_o.status = fdc_hp_pkg::ST_MOTOR | fdc_hp_pkg::ST_HEAD |
                                     ((step_trk == 8'd0) ? fdc_hp_pkg::ST_TRACK0 : 8'd0);
                  end
               end
               fdc_hp_pkg::SEL_TRACK:  regs_o.track  = req_i.write_data;
               fdc_hp_pkg::SEL_SECTOR: regs_o.sector = req_i.write_data;
               default:                regs_o.data   = req_i.write_data;
            endcase
         end
         fdc_hp_pkg::CMD_TICK: begin
            if (regs_i.motor_on && !regs_i.status[fdc_hp_pkg::ST_BUSY_BIT] &&
                regs_i.countdown != 7'd0) begin
               regs_o.countdown = regs_i.countdown - 7'd1;
               if (regs_i.countdown == 7'd1) begin
                  regs_o.motor_on = 1'b0;
               end
            end
         end
         default: begin
            // The unused access code changes nothing.
         end
      endcase
   end

endmodule

// ===== rtl/core/fdc_head_positioning_registers_top.sv =====
// Top level of the floppy head-positioning register block.
// Holds the register file, per-drive head tracks and the response register.
// Depends on fdc_hp_pkg and fdc_hp_cmd.

// Each request (bus read, bus write or motor tick) is decoded in the cycle it is
// accepted, and its response appears in the response register on the next cycle.
// One request is taken every clock cycle; the only limit is the single response
// register, which still takes a new request in the same cycle its current response
// is taken. All command effects, including Type I head moves, complete within the
// request, so a following request always sees the updated registers. Configuration
// writes on the csr_ port take effect at the next clock edge and are meant to be
// done while no request is outstanding.
module fdc_head_positioning_registers_top #(
   parameter int NUM_DRIVES = fdc_hp_pkg::DEF_NUM_DRIVES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] cmd, [3:2] reg_sel, [11:4] write_data, [15:12] zero
   input  logic [fdc_hp_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] read_data, [8] motor_running, [15:9] zero
   output logic [fdc_hp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [1:0]                         csr_wdata
);

   localparam int DRV_W = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;

   fdc_hp_pkg::req_type      req;
   fdc_hp_pkg::regs_type     regs_ff;
   fdc_hp_pkg::regs_type     regs_in;
   fdc_hp_pkg::head_upd_type head_upd;
   logic [7:0]               head_ff [NUM_DRIVES];
   logic [DRV_W-1:0]         drv_idx;
   logic                     drv_eff;
   logic                     drive_select_ff;
   logic [1:0]               disk_mask_ff;
   logic [7:0]               read_data;
   logic                     req_fire;
   logic                     rsp_tvalid_ff;
   logic [7:0]               rsp_read_ff;
   logic                     rsp_motor_ff;

   assign req      = fdc_hp_pkg::req_type'(req_tdata[11:0]);
   assign req_fire = req_tvalid && req_tready;
   assign req_tready = !rsp_tvalid_ff || rsp_tready;

   // With one drive the selection wraps to drive zero.
   assign drv_eff = (NUM_DRIVES > 1) ? drive_select_ff : 1'b0;
   assign drv_idx = DRV_W'(drv_eff);

   fdc_hp_cmd u_cmd (
      .req_i       (req),
      .regs_i      (regs_ff),
      .head_i      (head_ff[drv_idx]),
      .disk_i      (disk_mask_ff[drv_eff]),
      .regs_o      (regs_in),
      .head_o      (head_upd),
      .read_data_o (read_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_select_ff <= 1'b0;
         disk_mask_ff    <= 2'd0;
      end else if (csr_we) begin
         case (csr_index)
            fdc_hp_pkg::CSR_DRIVE_SELECT: drive_select_ff <= csr_wdata[0];
            fdc_hp_pkg::CSR_DISK_PRESENT: disk_mask_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.track        <= 8'd0;
         regs_ff.sector       <= 8'd1;
         regs_ff.data         <= 8'd0;
         regs_ff.status       <= 8'd0;
         regs_ff.step_outward <= 1'b0;
         regs_ff.motor_on     <= 1'b0;
         regs_ff.countdown    <= 7'd0;
         for (int i = 0; i < NUM_DRIVES; i++) begin
            head_ff[i] <= 8'd0;
         end
      end else if (req_fire) begin
         regs_ff <= regs_in;
         if (head_upd.we) begin
            head_ff[drv_idx] <= head_upd.track;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_read_ff  <= read_data;
         rsp_motor_ff <= regs_in.motor_on;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_motor_ff, rsp_read_ff};

   // The countdown only runs while the motor is on and is cleared with it.
   a_motor_off_count_zero : assert property (@(posedge clock) disable iff (reset)
      !regs_ff.motor_on |-> regs_ff.countdown == 7'd0)
      else $error("motor countdown nonzero while motor is off");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      regs_ff.countdown <= fdc_hp_pkg::MOTOR_TICKS)
      else $error("motor countdown above reload value");

   a_accept_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("accepted request produced no response");

   a_no_busy : assert property (@(posedge clock) disable iff (reset)
      !regs_ff.status[fdc_hp_pkg::ST_BUSY_BIT])
      else $error("busy status bit set by an instant command");

   a_rsp_motor_matches : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_motor_ff == regs_ff.motor_on)
      else $error("reported motor flag differs from register state");

endmodule

// ===== test/fdc_head_positioning_registers_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fdc_head_positioning_registers_top.
// Directed table, then random phases; a register model predicts responses not typed in.
// Depends on fdc_hp_pkg and the block's RTL.
module fdc_head_positioning_registers_top_tb;

   localparam int NUM_DRIVES = fdc_hp_pkg::DEF_NUM_DRIVES;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS = 233;
   localparam int NUM_PHASES = 7;
   localparam int DIR_ROWS = 26;
   localparam logic KNOWN = 1'b1;
   localparam logic PREDICTED = 1'b0;
   localparam int RDY_ALWAYS = 0;
   localparam int RDY_MOSTLY = 1;
   localparam int RDY_PATTERN = 2;
   localparam int RDY_RARELY = 3;

   typedef struct packed {
      logic [7:0] read_data;
      logic       motor_running;
   } bus_rsp_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [1:0] sel;
      logic [7:0] wd;
      logic       known;
      logic [7:0] rd;
      logic       motor;
   } dir_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [fdc_hp_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [fdc_hp_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                               csr_we = 1'b0;
   logic                               csr_index = fdc_hp_pkg::CSR_DRIVE_SELECT;
   logic [1:0]                         csr_wdata = '0;

   // Expected values typed into the directed table travel beside the request.
   logic       note_known = 1'b0;
   logic [7:0] note_rd = '0;
   logic       note_motor = 1'b0;

   // Register model of the block.
   logic [7:0] hp_track, hp_sector, hp_data, hp_status;
   logic       hp_outward, hp_motor;
   logic [6:0] hp_countdown;
   logic [7:0] hp_head [NUM_DRIVES];
   logic       cfg_drive;
   logic [1:0] cfg_disks;

   bus_rsp_type         pending_rsp [$];
   bus_rsp_type         predicted, oldest;
   fdc_hp_pkg::req_type seen_req;
   int         req_count = 0;
   int         rsp_count = 0;
   int         mismatch_count = 0;
   int         quiet_cycles = 0;
   int         burst_left = 0;
   int         rdy_mode = RDY_ALWAYS;
   logic [15:0] rdy_mask = '1;
   logic [5:0] rdy_phase = '0;
   dir_row_type dir_rows [DIR_ROWS];
   logic       phase_drive [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
   logic [1:0] phase_disks [NUM_PHASES] = '{2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};

   fdc_head_positioning_registers_top #(
      .NUM_DRIVES(NUM_DRIVES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic hp_reset();
      hp_track = '0;
      hp_sector = 8'd1;
      hp_data = '0;
      hp_status = '0;
      hp_outward = 1'b0;
      hp_motor = 1'b0;
      hp_countdown = '0;
      cfg_drive = 1'b0;
      cfg_disks = '0;
      for (int d = 0; d < NUM_DRIVES; d++) hp_head[d] = '0;
   endtask

   function automatic int hp_drive();
      return int'(cfg_drive) % NUM_DRIVES;
   endfunction

   function automatic logic hp_disk_here();
      int d;
      d = hp_drive();
      if (d > 1) return 1'b0;
      return cfg_disks[d];
   endfunction

   task automatic hp_motor_start();
      hp_motor = 1'b1;
      hp_countdown = fdc_hp_pkg::MOTOR_TICKS;
   endtask

   task automatic hp_step(input logic [7:0] op, input logic outward);
      int d;
      int t;
      d = hp_drive();
      t = hp_head[d];
      hp_motor_start();
      hp_outward = outward;
      if (outward) t = (t == 0) ? 0 : t - 1;
      else t = t + 1;
      if (t > fdc_hp_pkg::LAST_TRACK) t = fdc_hp_pkg::LAST_TRACK;
      hp_head[d] = 8'(t);
      if (op[fdc_hp_pkg::UPDATE_BIT]) hp_track = 8'(t);
      hp_status = fdc_hp_pkg::ST_MOTOR | fdc_hp_pkg::ST_HEAD |
                  ((t == 0) ? fdc_hp_pkg::ST_TRACK0 : 8'h00);
   endtask

   task automatic hp_command(input logic [7:0] op);
      int d;
      logic [7:0] target;
      d = hp_drive();
      target = hp_data;
      case (op[7:4])
         fdc_hp_pkg::OP_FORCE_INT: begin
            hp_status = fdc_hp_pkg::ST_MOTOR | fdc_hp_pkg::ST_HEAD;
            if (hp_head[d] == 0) hp_status |= fdc_hp_pkg::ST_TRACK0;
            if (!hp_disk_here()) hp_status &= ~fdc_hp_pkg::ST_MOTOR;
            hp_motor_start();
         end
         fdc_hp_pkg::OP_RESTORE: begin
            hp_motor_start();
            hp_head[d] = '0;
            hp_track = '0;
            hp_outward = 1'b1;
            hp_status = fdc_hp_pkg::ST_MOTOR | fdc_hp_pkg::ST_HEAD | fdc_hp_pkg::ST_TRACK0;
            if (!hp_disk_here()) hp_status |= fdc_hp_pkg::ST_SEEKERR;
         end
         fdc_hp_pkg::OP_SEEK: begin
            hp_motor_start();
            if (target > hp_track) hp_outward = 1'b0;
            else if (target < hp_track) hp_outward = 1'b1;
            hp_head[d] = target;
            hp_track = target;
            hp_status = fdc_hp_pkg::ST_MOTOR | fdc_hp_pkg::ST_HEAD;
            if (target == 0) hp_status |= fdc_hp_pkg::ST_TRACK0;
            if (!hp_disk_here()) hp_status |= fdc_hp_pkg::ST_SEEKERR;
         end
         fdc_hp_pkg::OP_STEP, fdc_hp_pkg::OP_STEP_U: hp_step(op, hp_outward);
         fdc_hp_pkg::OP_STEP_IN, fdc_hp_pkg::OP_STEP_IN_U: hp_step(op, 1'b0);
         fdc_hp_pkg::OP_STEP_OUT, fdc_hp_pkg::OP_STEP_OUT_U: hp_step(op, 1'b1);
         default: ;
      endcase
   endtask

   task automatic hp_predict(input fdc_hp_pkg::req_type r, output bus_rsp_type res);
      res.read_data = '0;
      case (r.cmd)
         fdc_hp_pkg::CMD_READ: begin
            case (r.reg_sel)
               fdc_hp_pkg::SEL_STATUS: res.read_data = hp_status;
               fdc_hp_pkg::SEL_TRACK:  res.read_data = hp_track;
               fdc_hp_pkg::SEL_SECTOR: res.read_data = hp_sector;
               default:                res.read_data = hp_data;
            endcase
         end
         fdc_hp_pkg::CMD_WRITE: begin
            case (r.reg_sel)
               fdc_hp_pkg::SEL_STATUS: hp_command(r.write_data);
               fdc_hp_pkg::SEL_TRACK:  hp_track = r.write_data;
               fdc_hp_pkg::SEL_SECTOR: hp_sector = r.write_data;
               default:                hp_data = r.write_data;
            endcase
         end
         fdc_hp_pkg::CMD_TICK: begin
            if (hp_motor && !hp_status[fdc_hp_pkg::ST_BUSY_BIT] && hp_countdown != 0) begin
               hp_countdown = hp_countdown - 7'd1;
               if (hp_countdown == 0) hp_motor = 1'b0;
            end
         end
         default: ;
      endcase
      res.motor_running = hp_motor;
   endtask

   // Requests are predicted in acceptance order; responses are checked against the oldest.
   always @(posedge clock) begin
      if (reset) begin
         hp_reset();
      end else begin
         if (req_tvalid && req_tready) begin
            seen_req = fdc_hp_pkg::req_type'(req_tdata[$bits(fdc_hp_pkg::req_type)-1:0]);
            hp_predict(seen_req, predicted);
            if (note_known) begin
               predicted.read_data = note_rd;
               predicted.motor_running = note_motor;
            end
            pending_rsp.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (pending_rsp.size() == 0) begin
               $error("read_data: response 0x%h with no request pending", rsp_tdata);
               mismatch_count++;
            end else begin
               oldest = pending_rsp.pop_front();
               if (rsp_tdata[7:0] !== oldest.read_data) begin
                  $error("read_data: expected 0x%h, got 0x%h", oldest.read_data, rsp_tdata[7:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[8] !== oldest.motor_running) begin
                  $error("motor_running: expected %b, got %b", oldest.motor_running,
                         rsp_tdata[8]);
                  mismatch_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               fdc_hp_pkg::CSR_DRIVE_SELECT: cfg_drive = csr_wdata[0];
               default:                      cfg_disks = csr_wdata;
            endcase
         end
      end
   end

   // The receiver switches between stall behaviors each time the 6-bit phase counter wraps.
   always @(posedge clock) begin
      rdy_phase <= rdy_phase + 6'd1;
      if (rdy_phase == 0) begin
         rdy_mode <= $urandom_range(RDY_ALWAYS, RDY_RARELY);
         rdy_mask <= 16'($urandom);
      end
      case (rdy_mode)
         RDY_ALWAYS:  rsp_tready <= 1'b1;
         RDY_MOSTLY:  rsp_tready <= ($urandom_range(0, 3) != 0);
         RDY_PATTERN: rsp_tready <= rdy_mask[rdy_phase[3:0]];
         default:     rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("fdc_head_positioning_registers_top: mismatch");
         $finish;
      end
   end

   task automatic send_request(input logic [1:0] cmd, input logic [1:0] sel,
                               input logic [7:0] wd, input logic known = PREDICTED,
                               input logic [7:0] rd = '0, input logic motor = 1'b0);
      fdc_hp_pkg::req_type r;
      r.cmd = cmd;
      r.reg_sel = sel;
      r.write_data = wd;
      req_tvalid <= 1'b1;
      req_tdata <= fdc_hp_pkg::REQ_TDATA_W'(r);
      note_known <= known;
      note_rd <= rd;
      note_motor <= motor;
      do @(posedge clock); while (!req_tready);
      req_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 12);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (rsp_count != req_count) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Seek targets lean toward the track limits and the byte extremes.
   function automatic logic [7:0] track_byte();
      int pick;
      pick = $urandom_range(0, 5);
      if (pick == 0) return 8'h00;
      if (pick == 1) return fdc_hp_pkg::LAST_TRACK;
      if (pick == 2) return fdc_hp_pkg::LAST_TRACK + 8'd1;
      if (pick == 3) return 8'hFF;
      return 8'($urandom);
   endfunction

   task automatic random_phase(input int n_items);
      int start;
      int pick;
      int reps;
      logic [1:0] sel;
      start = req_count;
      while (req_count - start < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            send_request(2'($urandom), 2'($urandom), 8'($urandom));
         end else if (pick < 40) begin
            send_request(fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_DATA, track_byte());
            send_request(fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_STATUS,
                         {fdc_hp_pkg::OP_SEEK, 4'($urandom)});
            send_request(fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_TRACK, 8'($urandom));
            send_request(fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_STATUS, 8'($urandom));
         end else if (pick < 65) begin
            reps = $urandom_range(1, 6);
            repeat (reps) begin
               send_request(fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_STATUS,
                            {4'($urandom_range(fdc_hp_pkg::OP_STEP, fdc_hp_pkg::OP_STEP_OUT_U)),
                             4'($urandom)});
               send_request(fdc_hp_pkg::CMD_READ, 2'($urandom), 8'($urandom));
            end
         end else if (pick < 75) begin
            send_request(fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_STATUS,
                         {fdc_hp_pkg::OP_RESTORE, 4'($urandom)});
            send_request(fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_STATUS, 8'($urandom));
         end else if (pick < 83) begin
            send_request(fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_STATUS,
                         {fdc_hp_pkg::OP_FORCE_INT, 4'($urandom)});
            send_request(fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_STATUS, 8'($urandom));
            send_request(fdc_hp_pkg::CMD_TICK, 2'($urandom), 8'($urandom));
         end else if (pick < 95) begin
            sel = 2'($urandom_range(fdc_hp_pkg::SEL_TRACK, fdc_hp_pkg::SEL_DATA));
            send_request(fdc_hp_pkg::CMD_WRITE, sel,
                         ($urandom_range(0, 1) == 0) ? track_byte() : 8'($urandom));
            send_request(fdc_hp_pkg::CMD_READ, sel, 8'($urandom));
         end else begin
            // A long run of ticks lets the motor countdown expire, or nearly so.
            reps = $urandom_range(90, 110);
            repeat (reps) begin
               if ($urandom_range(0, 7) == 0) begin
                  send_request(fdc_hp_pkg::CMD_READ, 2'($urandom), 8'($urandom));
               end else begin
                  send_request(fdc_hp_pkg::CMD_TICK, 2'($urandom), 8'($urandom));
               end
            end
            send_request(fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_STATUS, 8'($urandom));
         end
      end
   endtask

   initial begin
      dir_rows = '{
         '{fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_STATUS, 8'h00, KNOWN, 8'h00, 1'b0},
         '{fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_TRACK, 8'h00, KNOWN, 8'h00, 1'b0},
         '{fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_SECTOR, 8'h00, KNOWN, 8'h01, 1'b0},
         '{fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_DATA, 8'h00, KNOWN, 8'h00, 1'b0},
         '{CMD_UNUSED, fdc_hp_pkg::SEL_DATA, 8'hFF, KNOWN, 8'h00, 1'b0},
         '{fdc_hp_pkg::CMD_TICK, fdc_hp_pkg::SEL_STATUS, 8'h00, KNOWN, 8'h00, 1'b0},
         '{fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_DATA, 8'hFF, KNOWN, 8'h00, 1'b0},
         '{fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_DATA, 8'h00, KNOWN, 8'hFF, 1'b0},
         '{fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_STATUS, {fdc_hp_pkg::OP_SEEK, 4'hF},
           KNOWN, 8'h00, 1'b1},
         '{fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_TRACK, 8'h00, KNOWN, 8'hFF, 1'b1},
         '{fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_STATUS, 8'h00, KNOWN,
           fdc_hp_pkg::ST_MOTOR | fdc_hp_pkg::ST_HEAD | fdc_hp_pkg::ST_SEEKERR, 1'b1},
         '{fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_STATUS, {fdc_hp_pkg::OP_STEP_IN_U, 4'h0},
           KNOWN, 8'h00, 1'b1},
         '{fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_TRACK, 8'h00, KNOWN,
           fdc_hp_pkg::LAST_TRACK, 1'b1},
         '{fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_STATUS, {fdc_hp_pkg::OP_RESTORE, 4'h0},
           KNOWN, 8'h00, 1'b1},
         '{fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_STATUS, 8'h00, KNOWN,
           fdc_hp_pkg::ST_MOTOR | fdc_hp_pkg::ST_HEAD | fdc_hp_pkg::ST_TRACK0 |
           fdc_hp_pkg::ST_SEEKERR, 1'b1},
         '{fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_STATUS, {fdc_hp_pkg::OP_STEP_OUT_U, 4'hF},
           PREDICTED, 8'h00, 1'b0},
         '{fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_STATUS, 8'h00, KNOWN,
           fdc_hp_pkg::ST_MOTOR | fdc_hp_pkg::ST_HEAD | fdc_hp_pkg::ST_TRACK0, 1'b1},
         '{fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_STATUS, {fdc_hp_pkg::OP_STEP, 4'h0},
           PREDICTED, 8'h00, 1'b0},
         '{fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_STATUS, {fdc_hp_pkg::OP_FORCE_INT, 4'h0},
           PREDICTED, 8'h00, 1'b0},
         '{fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_STATUS, 8'h00, KNOWN,
           fdc_hp_pkg::ST_HEAD | fdc_hp_pkg::ST_TRACK0, 1'b1},
         '{fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_STATUS, 8'h80, PREDICTED, 8'h00, 1'b0},
         '{fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_STATUS, 8'hFF, PREDICTED, 8'h00, 1'b0},
         '{fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_SECTOR, 8'h00, PREDICTED, 8'h00, 1'b0},
         '{fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_SECTOR, 8'h00, KNOWN, 8'h00, 1'b1},
         '{fdc_hp_pkg::CMD_WRITE, fdc_hp_pkg::SEL_STATUS, {fdc_hp_pkg::OP_STEP_IN, 4'h0},
           PREDICTED, 8'h00, 1'b0},
         '{fdc_hp_pkg::CMD_READ, fdc_hp_pkg::SEL_TRACK, 8'h00, KNOWN, 8'h00, 1'b1}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIR_ROWS; i++) begin
         send_request(dir_rows[i].cmd, dir_rows[i].sel, dir_rows[i].wd, dir_rows[i].known,
                      dir_rows[i].rd, dir_rows[i].motor);
      end
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         write_csr(fdc_hp_pkg::CSR_DRIVE_SELECT, {1'b0, phase_drive[p]});
         write_csr(fdc_hp_pkg::CSR_DISK_PRESENT, phase_disks[p]);
         random_phase(PHASE_ITEMS);
      end
      wait_idle();
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("fdc_head_positioning_registers_top: match");
      end else begin
         $display("fdc_head_positioning_registers_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/fdc_hp_pkg.sv
rtl/core/fdc_hp_cmd.sv
rtl/core/fdc_head_positioning_registers_top.sv
test/fdc_head_positioning_registers_top_tb.sv
